### hdl/lesf_pkg.sv
// Shared types and constants for the largest empty square finder.
// No dependencies; imported by every module of the block but lesf_ram.
`timescale 1ns / 1ps

package lesf_pkg;

  localparam int SizeW      = 11;   // square value / size width
  localparam int CoordW     = 10;   // reported row / column width
  localparam int ChW        = 8;    // map character width
  localparam int CfgW       = 11;   // widest configuration register
  localparam int CfgIdxW    = 3;
  localparam int DefMaxCols = 1024;
  localparam int DefMaxRows = 1024;

  localparam logic [SizeW-1:0] SizeSat = '1;

  localparam logic [CfgW-1:0] RstMapWidth  = 11'd1;
  localparam logic [CfgW-1:0] RstMapHeight = 11'd1;
  localparam logic [ChW-1:0]  RstEmpty     = 8'd46;
  localparam logic [ChW-1:0]  RstObstacle  = 8'd111;
  localparam logic [ChW-1:0]  RstFull      = 8'd120;

  typedef enum logic [CfgIdxW-1:0] {
    RegMapWidth  = 3'd0,
    RegMapHeight = 3'd1,
    RegEmptyChar = 3'd2,
    RegObstChar  = 3'd3,
    RegFullChar  = 3'd4
  } lesf_reg_e;

  typedef struct packed {
    logic [CfgW-1:0] map_width;
    logic [CfgW-1:0] map_height;
    logic [ChW-1:0]  empty_char;
    logic [ChW-1:0]  obstacle_char;
    logic [ChW-1:0]  full_char;
  } lesf_cfg_t;

  // per-cell position flags handed from the scanner to the evaluator
  typedef struct packed {
    logic top_row;
    logic left_col;
    logic last_col;
    logic last_map;
  } lesf_ctl_t;

endpackage

### hdl/lesf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lesf_cfg.sv
// Configuration register file for the square finder.
// Depends on lesf_pkg.
`timescale 1ns / 1ps

module lesf_cfg
  import lesf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output lesf_cfg_t          cfg_o
);

  lesf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lesf_reg_e'(cfg_idx_i))
        RegMapWidth:  cfg_d.map_width     = cfg_wdata_i;
        RegMapHeight: cfg_d.map_height    = cfg_wdata_i;
        RegEmptyChar: cfg_d.empty_char    = cfg_wdata_i[ChW-1:0];
        RegObstChar:  cfg_d.obstacle_char = cfg_wdata_i[ChW-1:0];
        RegFullChar:  cfg_d.full_char     = cfg_wdata_i[ChW-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width     <= RstMapWidth;
      cfg_q.map_height    <= RstMapHeight;
      cfg_q.empty_char    <= RstEmpty;
      cfg_q.obstacle_char <= RstObstacle;
      cfg_q.full_char     <= RstFull;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/lesf_scan.sv
// Raster position tracker: column/row counters and end-of-row/map flags.
// Depends on lesf_pkg.
`timescale 1ns / 1ps

module lesf_scan
  import lesf_pkg::*;
#(
  parameter int MAX_COLS = DefMaxCols,
  parameter int MAX_ROWS = DefMaxRows,
  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lesf_cfg_t       cfg_i,
  input  logic            accept_i,
  output logic [ColW-1:0] col_o,
  output logic [RowW-1:0] row_o,
  output lesf_ctl_t       ctl_o
);

  // compare widths: wide enough for the limit and for an 11-bit register
  localparam int CE = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;
  localparam int RE = (RowW + 1 > CfgW) ? RowW + 1 : CfgW;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CE-1:0]   w_raw, w_eff, col_nxt;
  logic [RE-1:0]   h_raw, h_eff, row_nxt;
  logic            col_end, row_end;

  always_comb begin
    w_raw = CE'(cfg_i.map_width);
    h_raw = RE'(cfg_i.map_height);
    if (w_raw == '0) begin
      w_eff = CE'(1);
    end else if (w_raw > CE'(MAX_COLS)) begin
      w_eff = CE'(MAX_COLS);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = RE'(1);
    end else if (h_raw > RE'(MAX_ROWS)) begin
      h_eff = RE'(MAX_ROWS);
    end else begin
      h_eff = h_raw;
    end
    col_nxt = CE'(col_q) + CE'(1);
    row_nxt = RE'(row_q) + RE'(1);
    col_end = (col_nxt >= w_eff);
    row_end = (row_nxt >= h_eff);

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_nxt[RowW-1:0];
      end else begin
        col_d = col_nxt[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o          = col_q;
  assign row_o          = row_q;
  assign ctl_o.top_row  = (row_q == '0);
  assign ctl_o.left_col = (col_q == '0);
  assign ctl_o.last_col = col_end;
  assign ctl_o.last_map = col_end && row_end;

endmodule

### hdl/lesf_eval.sv
// Cell evaluator: min-of-three update against the row store, best-square
// tracking, error collection and the result register. Depends on lesf_pkg.
`timescale 1ns / 1ps

module lesf_eval
  import lesf_pkg::*;
#(
  parameter int MAX_COLS = DefMaxCols,
  parameter int MAX_ROWS = DefMaxRows,
  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lesf_cfg_t         cfg_i,
  // accepted cell from the scanner side
  input  logic              accept_i,
  input  logic [ChW-1:0]    ch_i,
  input  logic [ColW-1:0]   col_i,
  input  logic [RowW-1:0]   row_i,
  input  lesf_ctl_t         ctl_i,
  output logic              block_o,
  // row store
  input  logic [SizeW-1:0]  up_rd_i,
  output logic              wr_en_o,
  output logic [ColW-1:0]   wr_addr_o,
  output logic [SizeW-1:0]  wr_data_o,
  // result
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SizeW-1:0]  square_size_o,
  output logic [CoordW-1:0] top_row_o,
  output logic [CoordW-1:0] left_col_o,
  output logic              map_error_o
);

  localparam int PW = (RowW > ColW) ? RowW : ColW;
  localparam int BW = ((PW > SizeW) ? PW : SizeW) + 1;

  logic              v_q, v_d;
  logic [ChW-1:0]    ch_q;
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  lesf_ctl_t         ctl_q;
  logic              fwd_q;
  logic [SizeW-1:0]  fwd_val_q;
  logic [SizeW-1:0]  left_q, left_d, diag_q, diag_d;
  logic [SizeW-1:0]  best_q, best_d;
  logic [CoordW-1:0] brow_q, brow_d, bcol_q, bcol_d;
  logic              bad_q, bad_d;
  logic              out_v_q, out_v_d;
  logic [SizeW-1:0]  o_size_q, o_size_d;
  logic [CoordW-1:0] o_row_q, o_row_d, o_col_q, o_col_d;
  logic              o_err_q, o_err_d;

  logic              fire, obst, bad_now, err;
  logic [SizeW-1:0]  up, mn, val;
  logic [BW-1:0]     row_top, col_left;

  always_comb begin
    // same-cycle write to the entry being read: take the written value
    up      = ctl_q.top_row ? '0 : (fwd_q ? fwd_val_q : up_rd_i);
    obst    = (ch_q == cfg_i.obstacle_char);
    bad_now = (ch_q != cfg_i.empty_char) && !obst;

    mn = up;
    if (left_q < mn) mn = left_q;
    if (diag_q < mn) mn = diag_q;
    if (obst) begin
      val = '0;
    end else if (ctl_q.top_row || ctl_q.left_col) begin
      val = SizeW'(1);
    end else begin
      val = (mn == SizeSat) ? SizeSat : mn + SizeW'(1);
    end

    row_top  = BW'(row_q) + BW'(1) - BW'(val);
    col_left = BW'(col_q) + BW'(1) - BW'(val);

    // the last cell of a map waits only while an older result is held
    fire    = v_q && !(ctl_q.last_map && out_v_q && out_stall_i);
    block_o = v_q && !fire;

    v_d = accept_i ? 1'b1 : (fire ? 1'b0 : v_q);

    err = bad_q || bad_now || (cfg_i.map_width == '0) || (cfg_i.map_height == '0) ||
          (cfg_i.empty_char == cfg_i.obstacle_char) ||
          (cfg_i.obstacle_char == cfg_i.full_char) ||
          (cfg_i.full_char == cfg_i.empty_char);

    left_d   = left_q;
    diag_d   = diag_q;
    best_d   = best_q;
    brow_d   = brow_q;
    bcol_d   = bcol_q;
    bad_d    = bad_q;
    o_size_d = o_size_q;
    o_row_d  = o_row_q;
    o_col_d  = o_col_q;
    o_err_d  = o_err_q;
    out_v_d  = out_v_q && out_stall_i;

    if (fire) begin
      left_d = ctl_q.last_col ? '0 : val;
      diag_d = ctl_q.last_col ? '0 : up;
      bad_d  = bad_q || bad_now;
      if (val > best_q) begin
        best_d = val;
        brow_d = row_top[CoordW-1:0];
        bcol_d = col_left[CoordW-1:0];
      end
      if (ctl_q.last_map) begin
        out_v_d  = 1'b1;
        o_err_d  = err;
        o_size_d = err ? '0 : best_d;
        o_row_d  = err ? '0 : brow_d;
        o_col_d  = err ? '0 : bcol_d;
        best_d   = '0;
        brow_d   = '0;
        bcol_d   = '0;
        bad_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      fwd_q   <= 1'b0;
      left_q  <= '0;
      diag_q  <= '0;
      best_q  <= '0;
      brow_q  <= '0;
      bcol_q  <= '0;
      bad_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= v_d;
      left_q  <= left_d;
      diag_q  <= diag_d;
      best_q  <= best_d;
      brow_q  <= brow_d;
      bcol_q  <= bcol_d;
      bad_q   <= bad_d;
      out_v_q <= out_v_d;
      if (accept_i) begin
        fwd_q <= fire && (col_q == col_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ch_q      <= ch_i;
      col_q     <= col_i;
      row_q     <= row_i;
      ctl_q     <= ctl_i;
      fwd_val_q <= val;
    end
    o_size_q <= o_size_d;
    o_row_q  <= o_row_d;
    o_col_q  <= o_col_d;
    o_err_q  <= o_err_d;
  end

  assign wr_en_o       = fire;
  assign wr_addr_o     = col_q;
  assign wr_data_o     = val;
  assign out_valid_o   = out_v_q;
  assign square_size_o = o_size_q;
  assign top_row_o     = o_row_q;
  assign left_col_o    = o_col_q;
  assign map_error_o   = o_err_q;

endmodule

### hdl/largest_empty_square_finder.sv
// Largest empty square finder: one map cell per clock in raster order unless
// stalled, with the result beat issued after the last cell of each map. Each
// cell costs one read and one write of the row store (one RAM entry per
// column), so it sustains one cell per cycle unless stalled; a cell is
// registered before its row-store update, and the result is registered once
// the last cell is evaluated. Input stalls only when the last cell of a map
// finds the previous result still waiting. Configure only while idle.
// Depends on lesf_pkg, lesf_cfg, lesf_scan, lesf_eval and lesf_ram.
`timescale 1ns / 1ps

module largest_empty_square_finder
  import lesf_pkg::*;
#(
  parameter int MAX_COLS = DefMaxCols,
  parameter int MAX_ROWS = DefMaxRows
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ChW-1:0]     cell_char_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SizeW-1:0]   square_size_o,
  output logic [CoordW-1:0]  top_row_o,
  output logic [CoordW-1:0]  left_col_o,
  output logic               map_error_o
);

  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  lesf_cfg_t       cfg;
  lesf_ctl_t       ctl;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic            accept, block;
  logic            wr_en;
  logic [ColW-1:0] wr_addr;
  logic [SizeW-1:0] wr_data, up_rd;

  assign in_stall_o = block;
  assign accept     = in_valid_i && !block;

  lesf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lesf_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .col_o    (col),
    .row_o    (row),
    .ctl_o    (ctl)
  );

  lesf_ram #(
    .WIDTH (SizeW),
    .DEPTH (MAX_COLS)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (up_rd)
  );

  lesf_eval #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .ch_i          (cell_char_i),
    .col_i         (col),
    .row_i         (row),
    .ctl_i         (ctl),
    .block_o       (block),
    .up_rd_i       (up_rd),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .square_size_o (square_size_o),
    .top_row_o     (top_row_o),
    .left_col_o    (left_col_o),
    .map_error_o   (map_error_o)
  );

endmodule

### hdl/lesf_checker.sv
// Port-level checks for the largest empty square finder, bound to the top.
// Depends on lesf_pkg and largest_empty_square_finder.
`timescale 1ns / 1ps

module lesf_checker
  import lesf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [SizeW-1:0]   square_size_o,
  input logic [CoordW-1:0]  top_row_o,
  input logic [CoordW-1:0]  left_col_o,
  input logic               map_error_o
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(square_size_o) &&
      $stable(top_row_o) && $stable(left_col_o) && $stable(map_error_o))
    else $error("result beat changed while stalled");

  // input backpressure only comes from a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && map_error_o |-> square_size_o == '0 && top_row_o == '0 &&
      left_col_o == '0)
    else $error("error result carries a square");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && square_size_o == '0 |-> top_row_o == '0 && left_col_o == '0)
    else $error("empty result carries a corner");

  // a fresh result beat follows an accepted final cell
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result beat without a final cell");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);

### verif/largest_empty_square_finder_tb.sv
// Self-checking testbench for largest_empty_square_finder: raster maps of cells go in,
// and each map's square result is checked against a behavioral model in this file.
// Depends on lesf_pkg and the block's RTL.
`timescale 1ns / 1ps

module largest_empty_square_finder_tb;
  import lesf_pkg::*;

  localparam int MaxCols      = DefMaxCols;
  localparam int MaxRows      = DefMaxRows;
  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 4;
  localparam int RandomCells  = 1700;

  typedef enum int {MapClean, MapOneBad, MapNoise} map_kind_e;
  typedef enum int {RxOpen, RxRandom, RxToggle, RxBlocked} rx_mode_e;

  typedef struct packed {
    logic [SizeW-1:0]  size;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              err;
  } square_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = RegMapWidth;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ChW-1:0]     cell_char_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SizeW-1:0]   square_size_o;
  logic [CoordW-1:0]  top_row_o;
  logic [CoordW-1:0]  left_col_o;
  logic               map_error_o;

  largest_empty_square_finder #(
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) uut (.*);

  always #5 clk_i = ~clk_i;

  // model copy of the registers and the scan state
  logic [CfgW-1:0]  width_reg  = RstMapWidth;
  logic [CfgW-1:0]  height_reg = RstMapHeight;
  logic [ChW-1:0]   empty_reg  = RstEmpty;
  logic [ChW-1:0]   obst_reg   = RstObstacle;
  logic [ChW-1:0]   full_reg   = RstFull;
  logic [SizeW-1:0] run_row [MaxCols];
  int unsigned      left_run = 0, diag_run = 0;
  int unsigned      col_pos = 0, row_pos = 0;
  int unsigned      best_size = 0, best_row = 0, best_col = 0;
  logic             bad_char_seen = 1'b0;
  square_t          expected_squares [$];

  logic [ChW-1:0]   map_cells [$];
  int unsigned      cells_queued = 0;
  int unsigned      cells_taken = 0;
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  logic             cell_taken = 1'b0;

  function automatic int unsigned clamp_dim(input logic [CfgW-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  task automatic track_cell(input logic [ChW-1:0] ch);
    int unsigned w, h, col, up, val;
    square_t sq;
    w = clamp_dim(width_reg, MaxCols);
    h = clamp_dim(height_reg, MaxRows);
    col = (col_pos >= MaxCols) ? MaxCols - 1 : col_pos;
    up = (row_pos > 0) ? 32'(run_row[col]) : 0;
    if (ch != empty_reg && ch != obst_reg) bad_char_seen = 1'b1;
    // obstacle match wins even when the markers collide
    if (ch == obst_reg) begin
      val = 0;
    end else if (row_pos == 0 || col == 0) begin
      val = 1;
    end else begin
      val = up;
      if (left_run < val) val = left_run;
      if (diag_run < val) val = diag_run;
      val = val + 1;
      if (val > SizeSat) val = SizeSat;
    end
    run_row[col] = SizeW'(val);
    left_run = val;
    diag_run = up;
    if (val > best_size) begin
      best_size = val;
      best_row = row_pos + 1 - val;
      best_col = col + 1 - val;
    end
    if (col + 1 < w) begin
      col_pos = col + 1;
      return;
    end
    col_pos = 0;
    left_run = 0;
    diag_run = 0;
    if (row_pos + 1 < h) begin
      row_pos = row_pos + 1;
      return;
    end
    sq = '0;
    if (bad_char_seen || width_reg == 0 || height_reg == 0 || empty_reg == obst_reg ||
        obst_reg == full_reg || full_reg == empty_reg) begin
      sq.err = 1'b1;
    end else begin
      sq.size = best_size[SizeW-1:0];
      sq.row = best_row[CoordW-1:0];
      sq.col = best_col[CoordW-1:0];
    end
    expected_squares.push_back(sq);
    row_pos = 0;
    best_size = 0;
    best_row = 0;
    best_col = 0;
    bad_char_seen = 1'b0;
  endtask

  function automatic void flag_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_cell(input logic [ChW-1:0] ch);
    map_cells.push_back(ch);
    cells_queued++;
  endtask

  task automatic queue_map(input map_kind_e kind, input int unsigned obst_pct);
    int unsigned cells, bad_at;
    logic [ChW-1:0] ch;
    cells = clamp_dim(width_reg, MaxCols) * clamp_dim(height_reg, MaxRows);
    bad_at = $urandom_range(0, cells - 1);
    for (int unsigned i = 0; i < cells; i++) begin
      if (kind == MapNoise) begin
        ch = ChW'($urandom_range(0, 255));
      end else if (kind == MapOneBad && i == bad_at) begin
        ch = $urandom_range(0, 1) ? full_reg : 8'($urandom_range(0, 255));
      end else begin
        ch = ($urandom_range(0, 99) < obst_pct) ? obst_reg : empty_reg;
      end
      queue_cell(ch);
    end
  endtask

  task automatic write_reg(input lesf_reg_e idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMapWidth:  width_reg = data;
      RegMapHeight: height_reg = data;
      RegEmptyChar: empty_reg = data[ChW-1:0];
      RegObstChar:  obst_reg = data[ChW-1:0];
      RegFullChar:  full_reg = data[ChW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_map_config(input logic [CfgW-1:0] w, h, input logic [ChW-1:0] e, o, f);
    write_reg(RegMapWidth, w);
    write_reg(RegMapHeight, h);
    write_reg(RegEmptyChar, CfgW'(e));
    write_reg(RegObstChar, CfgW'(o));
    write_reg(RegFullChar, CfgW'(f));
  endtask

  // block is idle once every cell is taken and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cells_taken != cells_queued || expected_squares.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // sender: bursts of beats with random gaps, some bursts back to back
  int unsigned burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || cell_taken)) begin
      if (gap_left > 0 || map_cells.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        cell_char_i <= map_cells.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: stall pattern is re-picked whenever its countdown runs out
  rx_mode_e    rx_mode = RxOpen;
  int unsigned rx_left = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxOpen:   out_stall_i <= 1'b0;
      RxRandom: out_stall_i <= ($urandom_range(0, 99) < 40);
      RxToggle: out_stall_i <= rx_left[1];
      default:  out_stall_i <= (rx_left % 32) < 12;
    endcase
  end

  always @(posedge clk_i) begin
    square_t want;
    if (rst_ni) begin
      cell_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        track_cell(cell_char_i);
        cells_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_squares.size() == 0) begin
          $display("%0t: result beat with none expected, actual size %0d row %0d col %0d err %0b",
                   $time, square_size_o, top_row_o, left_col_o, map_error_o);
          mismatches++;
        end else begin
          want = expected_squares.pop_front();
          flag_field("square_size", 32'(want.size), 32'(square_size_o));
          flag_field("top_row", 32'(want.row), 32'(top_row_o));
          flag_field("left_col", 32'(want.col), 32'(left_col_o));
          flag_field("map_error", 32'(want.err), 32'(map_error_o));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("[largest_empty_square_finder] ERROR");
        $finish;
      end
    end
  end

  initial begin
    string       pattern;
    int unsigned w, h, pick, base, small_cells, map_phase, maps;
    logic [ChW-1:0] e, o, f;
    foreach (run_row[i]) run_row[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config is a 1x1 map: empty, obstacle, and three bad characters
    queue_cell(RstEmpty);
    queue_cell(RstObstacle);
    queue_cell(8'h00);
    queue_cell(8'hFF);
    queue_cell(RstFull);
    wait_drained();

    // three 2x2 squares tie; the first in raster order must win
    set_map_config(11'd4, 11'd3, RstEmpty, RstObstacle, RstFull);
    pattern = "..o.....o...";
    foreach (pattern[i]) queue_cell(pattern[i]);
    wait_drained();

    // zero width
    set_map_config(11'd0, 11'd2, RstEmpty, RstObstacle, RstFull);
    queue_cell(RstEmpty);
    queue_cell(RstEmpty);
    wait_drained();

    // empty and obstacle markers collide
    set_map_config(11'd2, 11'd1, RstEmpty, RstEmpty, RstFull);
    queue_cell(RstEmpty);
    queue_cell(RstEmpty);
    wait_drained();

    // zero height
    set_map_config(11'd3, 11'd0, RstEmpty, RstObstacle, RstFull);
    repeat (3) queue_cell(RstEmpty);
    wait_drained();

    small_cells = 0;
    map_phase = 0;
    while (small_cells < RandomCells) begin
      base = cells_queued;
      if (map_phase == 2) begin
        // width beyond MAX_COLS, extreme marker codes
        set_map_config('1, 11'd1, 8'h00, 8'hFF, 8'h80);
        queue_map(MapClean, 60);
      end else begin
        pick = $urandom_range(0, 99);
        w = (pick < 5) ? 0 : (pick < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        if ($urandom_range(0, 99) < 5) h = 0;
        else h = (w > 12) ? $urandom_range(1, 4) : $urandom_range(1, 12);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          e = RstEmpty;
          o = RstObstacle;
          f = RstFull;
        end else begin
          e = ChW'($urandom_range(0, 255));
          do o = ChW'($urandom_range(0, 255)); while (o == e);
          do f = ChW'($urandom_range(0, 255)); while (f == e || f == o);
          if (pick >= 90) begin
            case ($urandom_range(0, 2))
              0: o = e;
              1: f = o;
              default: f = e;
            endcase
          end
        end
        set_map_config(CfgW'(w), CfgW'(h), e, o, f);
        maps = $urandom_range(1, 4);
        repeat (maps) begin
          pick = $urandom_range(0, 99);
          queue_map((pick < 70) ? MapClean : (pick < 90) ? MapOneBad : MapNoise,
                    $urandom_range(0, 45));
        end
      end
      small_cells += cells_queued - base;
      wait_drained();
      map_phase++;
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_squares.size() == 0) begin
      $display("[largest_empty_square_finder] OK");
    end else begin
      $display("[largest_empty_square_finder] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lesf_pkg.sv
hdl/lesf_ram.sv
hdl/lesf_cfg.sv
hdl/lesf_scan.sv
hdl/lesf_eval.sv
hdl/largest_empty_square_finder.sv
hdl/lesf_checker.sv
verif/largest_empty_square_finder_tb.sv
